@@ hw/rtl/multi_reader_byte_ring_buffer_unit_macros.svh @@
// Assertion macros for the ring buffer RTL.
`ifndef MULTI_READER_BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define MULTI_READER_BYTE_RING_BUFFER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication or plain property, checked at every rising edge outside reset.
`define MRBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen.
`define MRBR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MRBR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRBR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/mrbr_pkg.sv @@
// Shared constants, codes and types of the multi-reader byte ring buffer.
`timescale 1ns / 1ps
package mrbr_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF        = 4096;
    localparam int MAX_CHANNELS_DEF = 32;
    localparam int MAX_READ_DEF     = 64;

    // Fixed values
    localparam int MIN_SIZE    = 16;
    localparam int CMD_Q_DEPTH = 4;

    // Field widths
    localparam int MODE_W      = 2;
    localparam int CH_W        = 5;
    localparam int COUNT_W     = 7;
    localparam int DATA_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int FILL_W      = 13;
    localparam int SIZE_REG_W  = 13;
    localparam int CHANS_REG_W = 6;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    // Operation codes
    localparam logic [MODE_W-1:0] OP_WRITE     = 2'd0;
    localparam logic [MODE_W-1:0] OP_READ      = 2'd1;
    localparam logic [MODE_W-1:0] OP_FLUSH     = 2'd2;
    localparam logic [MODE_W-1:0] OP_FLUSH_ALL = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_CHANS = 2'd2;

    // Command kinds between front and back
    localparam logic [1:0] KIND_RES = 2'd0;  // single result, no store access
    localparam logic [1:0] KIND_WR  = 2'd1;  // store one byte, one result
    localparam logic [1:0] KIND_RD  = 2'd2;  // read cnt bytes, cnt results

    typedef struct packed {
        logic [1:0]          kind;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
        logic [FILL_W-1:0]   room;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  cnt;
    } t_cmd;

endpackage

@@ hw/rtl/mrbr_in_if.sv @@
// Input word channel of the ring buffer.
`timescale 1ns / 1ps
interface mrbr_in_if;
    import mrbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [CH_W-1:0]    channel;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  data;
    logic               last_byte;

    modport source (output valid, mode, channel, count, data, last_byte, input ready);
    modport sink   (input valid, mode, channel, count, data, last_byte, output ready);
endinterface

@@ hw/rtl/mrbr_out_if.sv @@
// Result word channel of the ring buffer.
`timescale 1ns / 1ps
interface mrbr_out_if;
    import mrbr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_byte;
    logic                last;
    logic [FILL_W-1:0]   fill;
    logic [FILL_W-1:0]   room;

    modport source (output valid, status, read_byte, last, fill, room, input ready);
    modport sink   (input valid, status, read_byte, last, fill, room, output ready);
endinterface

@@ hw/rtl/mrbr_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mrbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/mrbr_cmd_fifo.sv @@
// Short command queue between the front and the back.
`timescale 1ns / 1ps
module mrbr_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ hw/rtl/mrbr_front.sv @@
// Front: accepts words, keeps pointers and fill counts, issues commands.
`timescale 1ns / 1ps
module mrbr_front #(
    parameter int DEPTH        = mrbr_pkg::DEPTH_DEF,
    parameter int MAX_CHANNELS = mrbr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_READ     = mrbr_pkg::MAX_READ_DEF,
    localparam int SW          = $clog2(DEPTH + 1),
    localparam int AW          = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic                                i_buffer_mode,
    input  logic [SW-1:0]                       i_size,
    input  logic [mrbr_pkg::CHANS_REG_W-1:0]    i_chans,
    mrbr_in_if.sink                             i_item,
    input  logic                                i_q_full,
    output logic                                o_push,
    output mrbr_pkg::t_cmd                      o_cmd,
    output logic [AW-1:0]                       o_addr
);
    import mrbr_pkg::*;

    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LW   = (SW > COUNT_W) ? SW : COUNT_W;
    localparam int CW   = (SW > FILL_W) ? SW : FILL_W;
    localparam int SUMW = LW + 1;

    logic [AW-1:0] r_ws, n_ws;
    logic [AW-1:0] r_rs   [MAX_CHANNELS];
    logic [AW-1:0] n_rs   [MAX_CHANNELS];
    logic [SW-1:0] r_fill [MAX_CHANNELS];
    logic [SW-1:0] n_fill [MAX_CHANNELS];
    logic          r_in_req, n_in_req;
    logic          r_refused, n_refused;

    logic [MAX_CHANNELS-1:0] active, full, short_room, fail, fail_low;
    logic                    any_full, first_full, accept, ch_act;
    logic [CHW-1:0]          chi;
    logic [COUNT_W-1:0]      wlen, rcnt;
    logic [SW-1:0]           rep_fill, rep_room;
    logic [CW-1:0]           fill_x, room_x;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p, input logic [SW-1:0] s);
        logic [AW:0] inc;
        inc = (AW+1)'(p) + 1'b1;
        return (inc >= (AW+1)'(s)) ? '0 : AW'(inc);
    endfunction

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && !i_q_full;
    assign o_push       = accept;
    assign ch_act       = (CHANS_REG_W'(i_item.channel) < i_chans);
    assign chi          = CHW'(i_item.channel);
    assign wlen         = (i_item.count == '0) ? COUNT_W'(1) : i_item.count;
    assign rcnt         = (i_item.count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ)
                                                                : i_item.count;

    // Per-channel room checks, all channels side by side
    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            active[i]     = (CHANS_REG_W'(i) < i_chans);
            full[i]       = active[i] && (r_fill[i] >= i_size);
            short_room[i] = active[i] && !full[i] &&
                            (LW'(wlen) > LW'(i_size - r_fill[i]));
        end
    end

    assign fail       = full | short_room;
    assign fail_low   = fail & (~fail + MAX_CHANNELS'(1));
    assign first_full = |(fail_low & full);
    assign any_full   = |full;

    // Next state and command
    always_comb begin
        logic [SW:0]     f1;
        logic [SUMW-1:0] sum;
        logic [AW-1:0]   ws_nx;
        logic            wr_ok;

        n_ws      = r_ws;
        n_rs      = r_rs;
        n_fill    = r_fill;
        n_in_req  = r_in_req;
        n_refused = r_refused;
        f1        = '0;
        sum       = '0;
        wr_ok     = 1'b1;
        ws_nx     = f_next(r_ws, i_size);

        o_cmd.kind   = KIND_RES;
        o_cmd.status = ST_OK;
        o_cmd.data   = i_item.data;
        o_cmd.cnt    = '0;
        o_addr       = '0;

        case (i_item.mode)
            OP_WRITE: begin
                if (i_buffer_mode) begin
                    if (!r_in_req) begin
                        n_refused = |fail;
                        if (|fail) begin
                            o_cmd.status = first_full ? ST_FULL : ST_NO_ROOM;
                            wr_ok        = 1'b0;
                        end
                    end else if (r_refused) begin
                        o_cmd.status = any_full ? ST_FULL : ST_NO_ROOM;
                        wr_ok        = 1'b0;
                    end
                    if (wr_ok && any_full) begin
                        o_cmd.status = ST_FULL;
                        wr_ok        = 1'b0;
                    end
                end
                if (wr_ok) begin
                    n_ws       = ws_nx;
                    o_cmd.kind = KIND_WR;
                    o_addr     = ws_nx;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        f1 = (SW+1)'(r_fill[i]) + 1'b1;
                        if (active[i]) begin
                            if (f1 >= (SW+1)'(i_size)) begin
                                n_fill[i] = i_size;
                                n_rs[i]   = ws_nx;
                            end else begin
                                n_fill[i] = SW'(f1);
                            end
                        end
                    end
                end
                if (i_item.last_byte) begin
                    n_in_req  = 1'b0;
                    n_refused = 1'b0;
                end else begin
                    n_in_req  = 1'b1;
                end
            end
            OP_FLUSH_ALL: begin
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    if (active[i]) begin
                        n_rs[i]   = r_ws;
                        n_fill[i] = '0;
                    end
                end
            end
            default: begin
                if (!ch_act) begin
                    o_cmd.status = ST_BAD_CH;
                end else if (i_item.mode == OP_FLUSH) begin
                    n_rs[chi]   = r_ws;
                    n_fill[chi] = '0;
                end else if (rcnt == '0 || LW'(rcnt) > LW'(r_fill[chi])) begin
                    o_cmd.status = ST_SHORT;
                end else begin
                    o_cmd.kind  = KIND_RD;
                    o_cmd.cnt   = rcnt;
                    o_addr      = f_next(r_rs[chi], i_size);
                    sum         = SUMW'(r_rs[chi]) + SUMW'(rcnt);
                    if (sum >= SUMW'(i_size)) begin
                        sum = sum - SUMW'(i_size);
                    end
                    n_rs[chi]   = AW'(sum);
                    n_fill[chi] = r_fill[chi] - SW'(rcnt);
                end
            end
        endcase

        // Report of the addressed channel after the operation
        rep_fill    = ch_act ? n_fill[chi] : '0;
        rep_room    = ch_act ? (i_size - n_fill[chi]) : '0;
        fill_x      = CW'(rep_fill);
        room_x      = CW'(rep_room);
        o_cmd.fill  = fill_x[FILL_W-1:0];
        o_cmd.room  = room_x[FILL_W-1:0];
    end

    // State update; reconfiguration clears every pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ws      <= '0;
            r_in_req  <= 1'b0;
            r_refused <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_rs[i]   <= '0;
                r_fill[i] <= '0;
            end
        end else if (accept) begin
            r_ws      <= n_ws;
            r_in_req  <= n_in_req;
            r_refused <= n_refused;
            r_rs      <= n_rs;
            r_fill    <= n_fill;
        end
    end
endmodule

@@ hw/rtl/mrbr_back.sv @@
// Back: executes queued commands against the byte store and drives results.
`timescale 1ns / 1ps
module mrbr_back #(
    parameter int DEPTH = mrbr_pkg::DEPTH_DEF,
    localparam int SW   = $clog2(DEPTH + 1),
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [SW-1:0]  i_size,
    input  logic           i_empty,
    input  mrbr_pkg::t_cmd i_cmd,
    input  logic [AW-1:0]  i_addr,
    output logic           o_pop,
    mrbr_out_if.source     o_result
);
    import mrbr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CAP  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [AW-1:0]      r_addr, n_addr;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [DATA_W-1:0]  r_byte, n_byte;
    logic               r_last, n_last;
    logic [DATA_W-1:0]  ram_rdata;
    logic               ram_we;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p, input logic [SW-1:0] s);
        logic [AW:0] inc;
        inc = (AW+1)'(p) + 1'b1;
        return (inc >= (AW+1)'(s)) ? '0 : AW'(inc);
    endfunction

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign ram_we = o_pop && (i_cmd.kind == KIND_WR);

    mrbr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_addr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: one byte read per pass through RD, CAP, OUT
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_left  = r_left;
        n_byte  = r_byte;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_cmd   = i_cmd;
                    n_addr  = i_addr;
                    n_left  = i_cmd.cnt;
                    n_byte  = '0;
                    n_last  = 1'b1;
                    n_state = (i_cmd.kind == KIND_RD) ? S_RD : S_OUT;
                end
            end
            S_RD: begin
                n_addr  = f_next(r_addr, i_size);
                n_left  = r_left - 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                n_byte  = ram_rdata;
                n_last  = (r_left == '0);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_result.ready) begin
                    n_state = (r_cmd.kind == KIND_RD && r_left != '0) ? S_RD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_left <= n_left;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    // Result word
    assign o_result.valid     = (r_state == S_OUT);
    assign o_result.status    = r_cmd.status;
    assign o_result.read_byte = r_byte;
    assign o_result.last      = r_last;
    assign o_result.fill      = r_cmd.fill;
    assign o_result.room      = r_cmd.room;
endmodule

@@ hw/rtl/multi_reader_byte_ring_buffer_unit.sv @@
// Top level of the multi-reader byte ring buffer: config registers, front, queue, back.
//
//   channel    dir  handshake            payload
//   i_item     in   valid/ready          mode, channel, count, data, last_byte
//   o_result   out  valid/ready          status, read_byte, last, fill, room
//   APB cfg    in   psel/penable/pwrite  paddr, pwdata (prdata back), pready tied high
//
// The front takes one word per cycle while the command queue has space.
// The back handles a write, flush or error word as pop, then output, and a read of N
// bytes as pop, then store read, capture and output for each byte, in that order, as
// set by the single store port and the sequencer.
// Synchronous active-low reset; the byte store itself is not cleared, no sweep.
// A stalled result holds the back; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps
`include "multi_reader_byte_ring_buffer_unit_macros.svh"
module multi_reader_byte_ring_buffer_unit #(
    parameter int DEPTH        = mrbr_pkg::DEPTH_DEF,
    parameter int MAX_CHANNELS = mrbr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_READ     = mrbr_pkg::MAX_READ_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mrbr_in_if.sink                       i_item,
    mrbr_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrbr_pkg::PADDR_W-1:0]  paddr,
    input  logic [mrbr_pkg::PDATA_W-1:0]  pwdata,
    output logic [mrbr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mrbr_pkg::*;

    localparam int SW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (SW > SIZE_REG_W) ? SW : SIZE_REG_W;
    localparam int QW = $bits(t_cmd) + AW;

    logic                   r_mode;
    logic [SIZE_REG_W-1:0]  r_size;
    logic [CHANS_REG_W-1:0] r_chans;
    logic                   cfg_wr, clear;
    logic [1:0]             reg_idx;
    logic [CW-1:0]          size_x;
    logic [SW-1:0]          eff_size;
    logic [CHANS_REG_W-1:0] eff_chans;

    logic                   q_push, q_full, q_pop, q_empty;
    t_cmd                   f_cmd, b_cmd;
    logic [AW-1:0]          f_addr, b_addr;
    logic [QW-1:0]          q_rdata;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign clear   = cfg_wr && (reg_idx == REG_SIZE || reg_idx == REG_CHANS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_size  <= SIZE_REG_W'(4096);
            r_chans <= CHANS_REG_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:  r_mode  <= pwdata[0];
                REG_SIZE:  r_size  <= pwdata[SIZE_REG_W-1:0];
                REG_CHANS: r_chans <= pwdata[CHANS_REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:  prdata = PDATA_W'(r_mode);
            REG_SIZE:  prdata = PDATA_W'(r_size);
            REG_CHANS: prdata = PDATA_W'(r_chans);
            default:   prdata = '0;
        endcase
    end

    // Effective size and channel count
    always_comb begin
        size_x = CW'(r_size);
        if (size_x < CW'(MIN_SIZE)) begin
            size_x = CW'(MIN_SIZE);
        end
        if (size_x > CW'(DEPTH)) begin
            size_x = CW'(DEPTH);
        end
        eff_size  = SW'(size_x);
        eff_chans = r_chans;
        if (r_chans == '0) begin
            eff_chans = CHANS_REG_W'(1);
        end else if (r_chans > CHANS_REG_W'(MAX_CHANNELS)) begin
            eff_chans = CHANS_REG_W'(MAX_CHANNELS);
        end
    end

    mrbr_front #(
        .DEPTH        (DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_READ     (MAX_READ)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (clear),
        .i_buffer_mode (r_mode),
        .i_size        (eff_size),
        .i_chans       (eff_chans),
        .i_item        (i_item),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (f_cmd),
        .o_addr        (f_addr)
    );

    mrbr_cmd_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({f_cmd, f_addr}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    assign b_cmd  = q_rdata[QW-1:AW];
    assign b_addr = q_rdata[AW-1:0];

    mrbr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (eff_size),
        .i_empty  (q_empty),
        .i_cmd    (b_cmd),
        .i_addr   (b_addr),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

    // Checks
    `MRBR_ASSERT(a_status_code, i_clk, i_rst_n, o_result.valid |-> (o_result.status <= ST_SHORT), "result status out of range")
    `MRBR_ASSERT(a_byte_only_ok, i_clk, i_rst_n, (o_result.valid && o_result.status != ST_OK) |-> (o_result.read_byte == '0), "data byte on an error result")
    `MRBR_ASSERT(a_bad_ch_report, i_clk, i_rst_n, (o_result.valid && o_result.status == ST_BAD_CH) |-> (o_result.fill == '0 && o_result.room == '0), "inactive channel reported fill")
    `MRBR_NEVER(a_pop_while_busy, i_clk, i_rst_n, q_pop && o_result.valid, "queue popped while a result waits")
endmodule
